FILE: rtl/core/tmpr_pkg.sv
// Shared types and constants for the tile map pixel renderer core.
// Holds action and status codes, register indexes and the pipeline word type.
// No dependencies.
`timescale 1ns / 1ps

package tmpr_pkg;

   // Tile edge in pixels is 1 << TILE_SHIFT
   localparam int TILE_SHIFT = 3;

   localparam int DEF_MAP_ENTRIES    = 4096;
   localparam int DEF_PALETTE_PIXELS = 16384;
   localparam int DEF_COLOR_BITS     = 32;

   localparam int COORD_W    = 12;
   localparam int CSR_W      = 13;
   localparam int TILE_NUM_W = 16;
   localparam int PTR_W      = 8;
   localparam int DIV_STEPS  = TILE_NUM_W;

   localparam int TX_W       = COORD_W - TILE_SHIFT;
   localparam int ROWBASE_W  = TX_W + CSR_W;
   localparam int CELL_W     = ROWBASE_W + 1;
   localparam int SX_W       = PTR_W + TILE_SHIFT;
   localparam int SY_W       = TILE_NUM_W + TILE_SHIFT;
   localparam int STRIDE_W   = PTR_W + TILE_SHIFT;
   localparam int PPROD_W    = SY_W + STRIDE_W;
   localparam int PADDR_W    = PPROD_W + 1;

   typedef logic [1:0] action_type;
   localparam action_type ACT_MAP_LOAD = 2'd0;
   localparam action_type ACT_PAL_LOAD = 2'd1;
   localparam action_type ACT_RENDER   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_LOAD    = 2'd0;
   localparam status_type ST_WRITTEN = 2'd1;
   localparam status_type ST_NONE    = 2'd2;
   localparam status_type ST_RANGE   = 2'd3;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_MAP_WIDTH     = 3'd0;
   localparam csr_index_type CSR_MAP_HEIGHT    = 3'd1;
   localparam csr_index_type CSR_PAL_PER_ROW   = 3'd2;
   localparam csr_index_type CSR_SCREEN_WIDTH  = 3'd3;
   localparam csr_index_type CSR_SCREEN_HEIGHT = 3'd4;

   localparam logic [PTR_W-1:0] PTR_RESET = 8'd16;

   typedef struct packed {
      logic                valid;
      action_type          action;
      logic [13:0]         address;
      logic [31:0]         value;
      logic [COORD_W-1:0]  px;
      logic [COORD_W-1:0]  py;
      status_type          status;
   } item_type;

endpackage

FILE: rtl/core/tile_map_pixel_renderer_core.sv
// Tile map pixel renderer core: map store, pipelined divider, palette store.
// Depends on tmpr_pkg.
`timescale 1ns / 1ps

// Every action passes stages 1 to 3, the divider, the palette multiply and the
// palette access to the rsp_ ports. Throughput: one word per cycle, set by the
// 16-stage quotient pipeline and the single access stage of each store.
// busy stays low; the receiver cannot stall, so no backpressure exists.
// Reset clears pipeline valid bits and the map and screen registers and sets
// ptr_ff to PTR_RESET; the stores stay undefined until loaded.
module tile_map_pixel_renderer_core
   import tmpr_pkg::*;
#(
   parameter int MAP_ENTRIES    = DEF_MAP_ENTRIES,
   parameter int PALETTE_PIXELS = DEF_PALETTE_PIXELS,
   parameter int COLOR_BITS     = DEF_COLOR_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_action,
   input  logic [13:0]         req_address,
   input  logic [31:0]         req_value,
   input  logic [11:0]         req_pixel_x,
   input  logic [11:0]         req_pixel_y,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic [11:0]         rsp_out_x,
   output logic [11:0]         rsp_out_y,
   output logic [31:0]         rsp_pixel_color,
   input  logic                csr_we,
   input  csr_index_type       csr_index,
   input  logic [CSR_W-1:0]    csr_data
);

   localparam int MAP_AW = $clog2(MAP_ENTRIES);
   localparam int PAL_AW = $clog2(PALETTE_PIXELS);

   // registers
   logic [CSR_W-1:0] map_width_ff;
   logic [CSR_W-1:0] map_height_ff;
   logic [PTR_W-1:0] ptr_ff;
   logic [CSR_W-1:0] screen_width_ff;
   logic [CSR_W-1:0] screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff     <= '0;
         map_height_ff    <= '0;
         ptr_ff           <= PTR_RESET;
         screen_width_ff  <= '0;
         screen_height_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAP_WIDTH:     map_width_ff     <= csr_data;
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_data;
            CSR_PAL_PER_ROW:   ptr_ff           <= csr_data[PTR_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: capture request word
   item_type st1_ff, st1_in;

   always_comb begin
      st1_in         = '0;
      st1_in.valid   = start;
      st1_in.action  = req_action;
      st1_in.address = req_address;
      st1_in.value   = req_value;
      case (req_action)
         ACT_MAP_LOAD: st1_in.status = ST_LOAD;
         ACT_PAL_LOAD: st1_in.status = ST_LOAD;
         ACT_RENDER: begin
            st1_in.status = ST_WRITTEN;
            st1_in.px     = req_pixel_x;
            st1_in.py     = req_pixel_y;
         end
         default: st1_in.status = ST_NONE;
      endcase
   end

   // stage 2: clip and row base multiply
   item_type               st2_ff, st2_in;
   logic [TX_W-1:0]        tx1, ty1;
   logic [TX_W-1:0]        tx2_ff, tx2_in;
   logic [ROWBASE_W-1:0]   rowbase_ff, rowbase_in;
   logic                   off_screen, off_map;

   always_comb begin
      tx1        = st1_ff.px[COORD_W-1:TILE_SHIFT];
      ty1        = st1_ff.py[COORD_W-1:TILE_SHIFT];
      off_screen = (CSR_W'(st1_ff.px) >= screen_width_ff) ||
                   (CSR_W'(st1_ff.py) >= screen_height_ff);
      off_map    = (CSR_W'(tx1) >= map_width_ff) || (CSR_W'(ty1) >= map_height_ff);
      st2_in     = st1_ff;
      if (st1_ff.action == ACT_RENDER && st1_ff.status == ST_WRITTEN &&
          (off_screen || off_map)) begin
         st2_in.status = ST_NONE;
      end
      tx2_in     = tx1;
      rowbase_in = ROWBASE_W'(ty1) * ROWBASE_W'(map_width_ff);
   end

   // stage 3: tile store access
   item_type                st3_ff, st3_in;
   logic [CELL_W-1:0]       cell_addr;
   logic [31:0]             map_waddr;
   logic                    tile_we;
   logic [TILE_NUM_W-1:0]   tile_mem [MAP_ENTRIES];
   logic [TILE_NUM_W-1:0]   tile_rd_ff;

   always_comb begin
      cell_addr = CELL_W'(rowbase_ff) + CELL_W'(tx2_ff);
      map_waddr = 32'(st2_ff.address);
      tile_we   = st2_ff.valid && st2_ff.action == ACT_MAP_LOAD &&
                  (map_waddr < 32'(MAP_ENTRIES));
      st3_in    = st2_ff;
      if (st2_ff.action == ACT_RENDER && st2_ff.status == ST_WRITTEN &&
          cell_addr >= CELL_W'(MAP_ENTRIES)) begin
         st3_in.status = ST_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (tile_we) begin
         tile_mem[map_waddr[MAP_AW-1:0]] <= st2_ff.value[TILE_NUM_W-1:0];
      end
      tile_rd_ff <= tile_mem[cell_addr[MAP_AW-1:0]];
   end

   // divider: one quotient bit per stage
   item_type               dv_item_ff [DIV_STEPS+1];
   item_type               dv_item_in [DIV_STEPS+1];
   logic [PTR_W-1:0]       dv_rem_ff  [DIV_STEPS+1];
   logic [PTR_W-1:0]       dv_rem_in  [DIV_STEPS+1];
   logic [TILE_NUM_W-1:0]  dv_qd_ff   [DIV_STEPS+1];
   logic [TILE_NUM_W-1:0]  dv_qd_in   [DIV_STEPS+1];
   logic [PTR_W:0]         trial      [DIV_STEPS+1];

   always_comb begin
      dv_item_in[0] = st3_ff;
      if (st3_ff.action == ACT_RENDER && st3_ff.status == ST_WRITTEN) begin
         if (tile_rd_ff == '0) begin
            dv_item_in[0].status = ST_NONE;
         end else if (ptr_ff == '0) begin
            dv_item_in[0].status = ST_RANGE;
         end
      end
      dv_rem_in[0] = '0;
      dv_qd_in[0]  = tile_rd_ff - TILE_NUM_W'(1);
      trial[0]     = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dv_item_in[k] = dv_item_ff[k-1];
         trial[k]      = {dv_rem_ff[k-1], dv_qd_ff[k-1][TILE_NUM_W-1]};
         if (trial[k] >= {1'b0, ptr_ff}) begin
            dv_rem_in[k] = PTR_W'(trial[k] - {1'b0, ptr_ff});
            dv_qd_in[k]  = {dv_qd_ff[k-1][TILE_NUM_W-2:0], 1'b1};
         end else begin
            dv_rem_in[k] = trial[k][PTR_W-1:0];
            dv_qd_in[k]  = {dv_qd_ff[k-1][TILE_NUM_W-2:0], 1'b0};
         end
      end
   end

   // palette address multiply
   item_type              pm_ff, pm_in;
   logic [SX_W-1:0]       sx_ff, sx_in;
   logic [SY_W-1:0]       sy;
   logic [STRIDE_W-1:0]   stride;
   logic [PPROD_W-1:0]    pprod_ff, pprod_in;

   always_comb begin
      pm_in    = dv_item_ff[DIV_STEPS];
      sx_in    = {dv_rem_ff[DIV_STEPS], dv_item_ff[DIV_STEPS].px[TILE_SHIFT-1:0]};
      sy       = {dv_qd_ff[DIV_STEPS], dv_item_ff[DIV_STEPS].py[TILE_SHIFT-1:0]};
      stride   = {ptr_ff, TILE_SHIFT'(0)};
      pprod_in = PPROD_W'(sy) * PPROD_W'(stride);
   end

   // palette store access
   item_type              po_ff, po_in;
   logic [PADDR_W-1:0]    paddr;
   logic [31:0]           pal_waddr;
   logic                  pal_we;
   logic [COLOR_BITS-1:0] pal_mem [PALETTE_PIXELS];
   logic [COLOR_BITS-1:0] pal_rd_ff;

   always_comb begin
      paddr     = PADDR_W'(pprod_ff) + PADDR_W'(sx_ff);
      pal_waddr = 32'(pm_ff.address);
      pal_we    = pm_ff.valid && pm_ff.action == ACT_PAL_LOAD &&
                  (pal_waddr < 32'(PALETTE_PIXELS));
      po_in     = pm_ff;
      if (pm_ff.action == ACT_RENDER && pm_ff.status == ST_WRITTEN &&
          paddr >= PADDR_W'(PALETTE_PIXELS)) begin
         po_in.status = ST_RANGE;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[pal_waddr[PAL_AW-1:0]] <= pm_ff.value[COLOR_BITS-1:0];
      end
      pal_rd_ff <= pal_mem[paddr[PAL_AW-1:0]];
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff <= '0;
         st2_ff <= '0;
         st3_ff <= '0;
         pm_ff  <= '0;
         po_ff  <= '0;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_item_ff[k] <= '0;
         end
      end else begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         pm_ff  <= pm_in;
         po_ff  <= po_in;
         for (int k = 0; k <= DIV_STEPS; k++) begin
            dv_item_ff[k] <= dv_item_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      tx2_ff     <= tx2_in;
      rowbase_ff <= rowbase_in;
      sx_ff      <= sx_in;
      pprod_ff   <= pprod_in;
      for (int k = 0; k <= DIV_STEPS; k++) begin
         dv_rem_ff[k] <= dv_rem_in[k];
         dv_qd_ff[k]  <= dv_qd_in[k];
      end
   end

   // result word
   assign rsp_strobe      = po_ff.valid;
   assign rsp_status      = po_ff.status;
   assign rsp_out_x       = po_ff.px;
   assign rsp_out_y       = po_ff.py;
   assign rsp_pixel_color = (po_ff.status == ST_WRITTEN) ? 32'(pal_rd_ff) : 32'd0;

endmodule

FILE: bench/tile_map_pixel_renderer_core_tb.sv
// Self-checking bench for tile_map_pixel_renderer_core: a directed table, then random
// load/render traffic over several register settings, each word checked against a local
// tile map predictor. Depends on tmpr_pkg and the core RTL.
`timescale 1ns / 1ps

module tile_map_pixel_renderer_core_tb;
   import tmpr_pkg::*;

   localparam int MAP_DEPTH = DEF_MAP_ENTRIES;
   localparam int PAL_DEPTH = DEF_PALETTE_PIXELS;
   localparam int TILE_PX   = 1 << TILE_SHIFT;
   localparam action_type ACT_UNUSED = 2'd3;

   typedef struct packed {
      action_type   action;
      logic [13:0]  address;
      logic [31:0]  value;
      logic [11:0]  px;
      logic [11:0]  py;
   } req_word_type;

   typedef struct packed {
      status_type   status;
      logic [11:0]  x;
      logic [11:0]  y;
      logic [31:0]  color;
   } pixel_word_type;

   typedef struct packed {
      logic          is_csr;
      csr_index_type reg_idx;
      logic [12:0]   reg_data;
      req_word_type  w;
      logic          typed;
      status_type    want_st;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [1:0]          req_action;
   logic [13:0]         req_address;
   logic [31:0]         req_value;
   logic [11:0]         req_pixel_x;
   logic [11:0]         req_pixel_y;
   logic                rsp_strobe;
   logic [1:0]          rsp_status;
   logic [11:0]         rsp_out_x;
   logic [11:0]         rsp_out_y;
   logic [31:0]         rsp_pixel_color;
   logic                csr_we;
   csr_index_type       csr_index;
   logic [CSR_W-1:0]    csr_data;

   // predictor state
   logic [12:0]  map_w, map_h, scr_w, scr_h;
   logic [7:0]   per_row;
   bit   [15:0]  tile_mem [MAP_DEPTH];
   bit           tile_known [MAP_DEPTH];
   bit   [31:0]  pal_mem [PAL_DEPTH];
   bit           pal_known [PAL_DEPTH];

   pixel_word_type  pending [$];
   plan_row_type    plan [$];
   int              fail_count = 0;
   int              words_taken = 0;
   int              gap_pct = 0;

   tile_map_pixel_renderer_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_address     (req_address),
      .req_value       (req_value),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_pixel_color (rsp_pixel_color),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tile_map_pixel_renderer_core test failed");
      $finish;
   end

   function automatic req_word_type make_word(action_type a, logic [13:0] addr,
                                              logic [31:0] v, logic [11:0] x,
                                              logic [11:0] y);
      req_word_type w;
      w.action  = a;
      w.address = addr;
      w.value   = v;
      w.px      = x;
      w.py      = y;
      return w;
   endfunction

   function automatic plan_row_type word_row(action_type a, logic [13:0] addr,
                                             logic [31:0] v, logic [11:0] x,
                                             logic [11:0] y);
      plan_row_type r;
      r = '0;
      r.w = make_word(a, addr, v, x, y);
      return r;
   endfunction

   function automatic plan_row_type known_row(action_type a, logic [13:0] addr,
                                              logic [31:0] v, logic [11:0] x,
                                              logic [11:0] y, status_type st);
      plan_row_type r;
      r = word_row(a, addr, v, x, y);
      r.typed   = 1'b1;
      r.want_st = st;
      return r;
   endfunction

   function automatic plan_row_type reg_row(csr_index_type idx, logic [12:0] data);
      plan_row_type r;
      r = '0;
      r.is_csr   = 1'b1;
      r.reg_idx  = idx;
      r.reg_data = data;
      return r;
   endfunction

   // Resolve one screen pixel; report which store entries the lookup reads (-1 for none).
   function automatic pixel_word_type render_pixel(logic [11:0] x, logic [11:0] y,
                                                   output int map_rd, output int pal_rd);
      pixel_word_type res;
      longint tx, ty, cell_idx, n, idx, trow, tcol, sx, sy, paddr;
      res = '0;
      res.status = ST_NONE;
      res.x = x;
      res.y = y;
      map_rd = -1;
      pal_rd = -1;
      if (x >= scr_w || y >= scr_h) return res;
      tx = x >> TILE_SHIFT;
      ty = y >> TILE_SHIFT;
      if (tx >= map_w || ty >= map_h) return res;
      cell_idx = tx + ty * map_w;
      if (cell_idx >= MAP_DEPTH) return res;
      map_rd = int'(cell_idx);
      n = tile_known[cell_idx] ? tile_mem[cell_idx] : 0;
      if (n == 0) return res;
      if (per_row == 0) begin
         res.status = ST_RANGE;
         return res;
      end
      idx   = n - 1;
      trow  = idx / per_row;
      tcol  = idx % per_row;
      sx    = tcol * TILE_PX + (x % TILE_PX);
      sy    = trow * TILE_PX + (y % TILE_PX);
      paddr = sx + sy * (per_row * TILE_PX);
      if (paddr >= PAL_DEPTH) begin
         res.status = ST_RANGE;
         return res;
      end
      pal_rd = int'(paddr);
      res.status = ST_WRITTEN;
      res.color  = pal_mem[paddr];
      return res;
   endfunction

   function automatic pixel_word_type apply_word(req_word_type w);
      pixel_word_type res;
      int map_rd, pal_rd;
      res = '0;
      case (w.action)
         ACT_MAP_LOAD: begin
            if (w.address < MAP_DEPTH) begin
               tile_mem[w.address]   = w.value[15:0];
               tile_known[w.address] = 1'b1;
            end
            res.status = ST_LOAD;
         end
         ACT_PAL_LOAD: begin
            if (w.address < PAL_DEPTH) begin
               pal_mem[w.address]   = w.value;
               pal_known[w.address] = 1'b1;
            end
            res.status = ST_LOAD;
         end
         ACT_RENDER: res = render_pixel(w.px, w.py, map_rd, pal_rd);
         default:    res.status = ST_NONE;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic send_word(input req_word_type w, input bit typed,
                            input pixel_word_type want);
      int gap;
      pixel_word_type got;
      gap = 0;
      while (gap < 60 && $urandom_range(99) < gap_pct) gap++;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= w.action;
      req_address <= w.address;
      req_value   <= w.value;
      req_pixel_x <= w.px;
      req_pixel_y <= w.py;
      @(posedge clock);
      while (busy) @(posedge clock);
      got = apply_word(w);
      pending.push_back(typed ? want : got);
      words_taken++;
   endtask

   task automatic drain_words();
      start <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [12:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      case (idx)
         CSR_MAP_WIDTH:     map_w   = data;
         CSR_MAP_HEIGHT:    map_h   = data;
         CSR_PAL_PER_ROW:   per_row = data[7:0];
         CSR_SCREEN_WIDTH:  scr_w   = data;
         CSR_SCREEN_HEIGHT: scr_h   = data;
         default: ;
      endcase
   endtask

   task automatic program_regs(input int mw, input int mh, input int pr, input int sw,
                               input int sh);
      drain_words();
      write_reg(CSR_MAP_WIDTH, 13'(mw));
      write_reg(CSR_MAP_HEIGHT, 13'(mh));
      write_reg(CSR_PAL_PER_ROW, 13'(pr));
      write_reg(CSR_SCREEN_WIDTH, 13'(sw));
      write_reg(CSR_SCREEN_HEIGHT, 13'(sh));
      csr_we <= 1'b0;
   endtask

   // Mostly tile numbers that land inside the palette, some empty, some wild.
   function automatic logic [31:0] tile_value();
      logic [31:0] v;
      int pick, cap;
      v = $urandom;
      pick = $urandom_range(99);
      if (per_row == 0) cap = 256;
      else cap = (PAL_DEPTH / (per_row * TILE_PX) / TILE_PX) * per_row;
      if (pick < 10) v[15:0] = '0;
      else if (pick >= 15) v[15:0] = 16'($urandom_range(1, cap));
      return v;
   endfunction

   // Load any store entry the lookup would read before it was ever written.
   task automatic send_render(input logic [11:0] x, input logic [11:0] y);
      pixel_word_type look;
      int map_rd, pal_rd;
      look = render_pixel(x, y, map_rd, pal_rd);
      if (map_rd >= 0 && !tile_known[map_rd]) begin
         send_word(make_word(ACT_MAP_LOAD, 14'(map_rd), tile_value(), 12'($urandom),
                             12'($urandom)), 1'b0, '0);
         look = render_pixel(x, y, map_rd, pal_rd);
      end
      if (pal_rd >= 0 && !pal_known[pal_rd])
         send_word(make_word(ACT_PAL_LOAD, 14'(pal_rd), $urandom, 12'($urandom),
                             12'($urandom)), 1'b0, '0);
      send_word(make_word(ACT_RENDER, 14'($urandom), $urandom, x, y), 1'b0, '0);
   endtask

   task automatic run_phase(input int count);
      int first, pick, lim_x, lim_y;
      logic [11:0] x, y;
      first = words_taken;
      lim_x = int'(scr_w);
      if (int'(map_w) * TILE_PX < lim_x) lim_x = int'(map_w) * TILE_PX;
      if (lim_x > 4096) lim_x = 4096;
      lim_y = int'(scr_h);
      if (int'(map_h) * TILE_PX < lim_y) lim_y = int'(map_h) * TILE_PX;
      if (lim_y > 4096) lim_y = 4096;
      while (words_taken - first < count) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            x = 12'($urandom);
            y = 12'($urandom);
            if ($urandom_range(3) != 0 && lim_x > 0 && lim_y > 0) begin
               x = 12'($urandom_range(0, lim_x - 1));
               y = 12'($urandom_range(0, lim_y - 1));
            end
            send_render(x, y);
         end else if (pick < 75) begin
            send_word(make_word(ACT_MAP_LOAD, 14'($urandom_range(0, MAP_DEPTH - 1)),
                                tile_value(), 12'($urandom), 12'($urandom)), 1'b0, '0);
         end else if (pick < 80) begin
            send_word(make_word(ACT_MAP_LOAD, 14'($urandom), $urandom, 12'($urandom),
                                12'($urandom)), 1'b0, '0);
         end else if (pick < 92) begin
            send_word(make_word(ACT_PAL_LOAD, 14'($urandom), $urandom, 12'($urandom),
                                12'($urandom)), 1'b0, '0);
         end else begin
            send_word(make_word(ACT_UNUSED, 14'($urandom), $urandom, 12'($urandom),
                                12'($urandom)), 1'b0, '0);
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pixel_word_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending.size() == 0) begin
            report_mismatch("unexpected word status", 32'(rsp_status), '0);
         end else begin
            want = pending.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_out_x !== want.x)
               report_mismatch("out_x", 32'(rsp_out_x), 32'(want.x));
            if (rsp_out_y !== want.y)
               report_mismatch("out_y", 32'(rsp_out_y), 32'(want.y));
            if (rsp_pixel_color !== want.color)
               report_mismatch("pixel_color", rsp_pixel_color, want.color);
         end
      end
   end

   initial begin
      int mw, mh, pr, sw, sh;
      pixel_word_type want;
      reset       = 1'b1;
      start       = 1'b0;
      req_action  = ACT_MAP_LOAD;
      req_address = '0;
      req_value   = '0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_MAP_WIDTH;
      csr_data    = '0;
      map_w   = '0;
      map_h   = '0;
      per_row = PTR_RESET;
      scr_w   = '0;
      scr_h   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(known_row(ACT_RENDER, 0, 0, 0, 0, ST_NONE));
      plan.push_back(known_row(ACT_RENDER, '1, '1, '1, '1, ST_NONE));
      plan.push_back(known_row(ACT_UNUSED, '1, '1, '1, '1, ST_NONE));
      plan.push_back(known_row(ACT_MAP_LOAD, '1, '1, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_PAL_LOAD, '1, '1, 0, 0, ST_LOAD));
      plan.push_back(reg_row(CSR_MAP_WIDTH, 2));
      plan.push_back(reg_row(CSR_MAP_HEIGHT, 2));
      plan.push_back(reg_row(CSR_PAL_PER_ROW, 2));
      plan.push_back(reg_row(CSR_SCREEN_WIDTH, 24));
      plan.push_back(reg_row(CSR_SCREEN_HEIGHT, 16));
      plan.push_back(known_row(ACT_MAP_LOAD, 0, 32'h5a5a_0001, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_MAP_LOAD, 1, 32'habcd_0000, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_MAP_LOAD, 2, 32'h0000_0004, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_MAP_LOAD, 3, 32'h0000_ffff, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_PAL_LOAD, 0, 32'hdead_beef, 0, 0, ST_LOAD));
      plan.push_back(known_row(ACT_PAL_LOAD, 255, 32'h1234_5678, 0, 0, ST_LOAD));
      plan.push_back(word_row(ACT_RENDER, 0, 0, 0, 0));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 8, 0, ST_NONE));
      plan.push_back(word_row(ACT_RENDER, 0, 0, 7, 15));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 15, 15, ST_RANGE));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 20, 3, ST_NONE));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 24, 0, ST_NONE));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 0, 16, ST_NONE));
      plan.push_back(reg_row(CSR_MAP_WIDTH, 4096));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 0, 8, ST_NONE));
      plan.push_back(reg_row(CSR_PAL_PER_ROW, 0));
      plan.push_back(known_row(ACT_RENDER, 0, 0, 0, 0, ST_RANGE));

      gap_pct = 23;
      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            drain_words();
            write_reg(plan[i].reg_idx, plan[i].reg_data);
         end else begin
            if (csr_we) csr_we <= 1'b0;
            want = '0;
            want.status = plan[i].want_st;
            if (plan[i].w.action == ACT_RENDER) begin
               want.x = plan[i].w.px;
               want.y = plan[i].w.py;
            end
            send_word(plan[i].w, plan[i].typed, want);
         end
      end

      for (int p = 0; p < 7; p++) begin
         gap_pct = (p < 3) ? 23 : (p < 5) ? 80 : 0;
         case (p)
            0: begin
               mw = $urandom_range(1, 8);
               mh = $urandom_range(1, 8);
               pr = $urandom_range(1, 16);
               sw = mw * TILE_PX + $urandom_range(0, 8);
               sh = mh * TILE_PX + $urandom_range(0, 8);
            end
            1: begin
               mw = 4096; mh = 4096; pr = 128; sw = 4096; sh = 4096;
            end
            2: begin
               mw = $urandom_range(1, 32);
               mh = $urandom_range(1, 32);
               pr = 1; sw = 8191; sh = 8191;
            end
            3: begin
               mw = 8191; mh = 8191; pr = 255; sw = 4096; sh = 4096;
            end
            4: begin
               mw = $urandom_range(1, 16);
               mh = $urandom_range(1, 16);
               pr = 0; sw = mw * TILE_PX; sh = mh * TILE_PX;
            end
            5: begin
               mw = $urandom_range(1, 64);
               mh = $urandom_range(1, 64);
               pr = $urandom_range(1, 128);
               sw = $urandom_range(0, 4096);
               sh = $urandom_range(0, 4096);
            end
            default: begin
               mw = 0; mh = 0; pr = 0; sw = 0; sh = 0;
            end
         endcase
         program_regs(mw, mh, pr, sw, sh);
         run_phase(240);
      end

      drain_words();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tile_map_pixel_renderer_core test passed");
      else
         $display("tile_map_pixel_renderer_core test failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/tmpr_pkg.sv
rtl/core/tile_map_pixel_renderer_core.sv
bench/tile_map_pixel_renderer_core_tb.sv
